// ----- rtl/wdsa_pkg.sv -----
// Shared types, constants and tables for the Wilson Dirac site accumulator.
`timescale 1ns / 1ps
package wdsa_pkg;

   localparam int ANG_W        = 32;
   localparam int CORDIC_W     = 34;
   localparam int CORDIC_STEPS = 24;
   localparam int ITER_W       = 5;
   localparam int COEF_W       = 27;
   localparam int KAPPA_W      = 16;
   localparam int MU_W         = 20;
   localparam int QDEPTH       = 2;
   localparam int QCNT_W       = 2;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [KAPPA_W-1:0] KAPPA_RESET = 16'd16384;
   localparam logic [MU_W-1:0]    MU_RESET    = 20'd0;

   localparam logic REG_KAPPA = 1'b0;
   localparam logic REG_MU    = 1'b1;

   localparam logic [1:0] DIR_FWD_0 = 2'd0;
   localparam logic [1:0] DIR_FWD_1 = 2'd1;
   localparam logic [1:0] DIR_BWD_2 = 2'd2;
   localparam logic [1:0] DIR_BWD_3 = 2'd3;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SETUP  = 7'b0000010,
      ST_MU     = 7'b0000100,
      ST_CORDIC = 7'b0001000,
      ST_COEF   = 7'b0010000,
      ST_HOP    = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } back_state_type;

   typedef struct packed {
      logic [KAPPA_W-1:0] kappa;
      logic [MU_W-1:0]    mu;
   } cfg_type;

   typedef struct packed {
      logic              push;
      logic              pop;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

   function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [ITER_W-1:0] idx);
      logic signed [CORDIC_W-1:0] v;
      case (idx)
         5'd0:  v = 34'sd536870912;
         5'd1:  v = 34'sd316933406;
         5'd2:  v = 34'sd167458907;
         5'd3:  v = 34'sd85004756;
         5'd4:  v = 34'sd42667331;
         5'd5:  v = 34'sd21354465;
         5'd6:  v = 34'sd10679838;
         5'd7:  v = 34'sd5340245;
         5'd8:  v = 34'sd2670163;
         5'd9:  v = 34'sd1335087;
         5'd10: v = 34'sd667544;
         5'd11: v = 34'sd333772;
         5'd12: v = 34'sd166886;
         5'd13: v = 34'sd83443;
         5'd14: v = 34'sd41722;
         5'd15: v = 34'sd20861;
         5'd16: v = 34'sd10430;
         5'd17: v = 34'sd5215;
         5'd18: v = 34'sd2608;
         5'd19: v = 34'sd1304;
         5'd20: v = 34'sd652;
         5'd21: v = 34'sd326;
         5'd22: v = 34'sd163;
         5'd23: v = 34'sd81;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/wdsa_if.sv -----
// Request and response channel interfaces of the Wilson Dirac site accumulator.
`timescale 1ns / 1ps
interface wdsa_req_if #(
   parameter int DATA_WIDTH  = 32,
   parameter int PHASE_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    direction;
   logic signed [DATA_WIDTH-1:0]  own_up_re;
   logic signed [DATA_WIDTH-1:0]  own_up_im;
   logic signed [DATA_WIDTH-1:0]  own_dn_re;
   logic signed [DATA_WIDTH-1:0]  own_dn_im;
   logic signed [DATA_WIDTH-1:0]  nbr_up_re;
   logic signed [DATA_WIDTH-1:0]  nbr_up_im;
   logic signed [DATA_WIDTH-1:0]  nbr_dn_re;
   logic signed [DATA_WIDTH-1:0]  nbr_dn_im;
   logic [PHASE_WIDTH-1:0]        link_phase;

   modport source (output valid, direction, own_up_re, own_up_im, own_dn_re, own_dn_im,
                   nbr_up_re, nbr_up_im, nbr_dn_re, nbr_dn_im, link_phase, input ready);
   modport sink (input valid, direction, own_up_re, own_up_im, own_dn_re, own_dn_im,
                 nbr_up_re, nbr_up_im, nbr_dn_re, nbr_dn_im, link_phase, output ready);
endinterface

interface wdsa_rsp_if #(
   parameter int DATA_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [DATA_WIDTH-1:0]  out_up_re;
   logic signed [DATA_WIDTH-1:0]  out_up_im;
   logic signed [DATA_WIDTH-1:0]  out_dn_re;
   logic signed [DATA_WIDTH-1:0]  out_dn_im;
   logic                          saturated;

   modport source (output valid, out_up_re, out_up_im, out_dn_re, out_dn_im, saturated,
                   input ready);
   modport sink (input valid, out_up_re, out_up_im, out_dn_re, out_dn_im, saturated,
                 output ready);
endinterface

// ----- rtl/wdsa_front.sv -----
// Front end: accepts requests, classifies the direction and packs them for the queue.
`timescale 1ns / 1ps
module wdsa_front #(
   parameter int DATA_WIDTH  = 32,
   parameter int PHASE_WIDTH = 16,
   parameter int ITEM_W      = 37 + 8 * DATA_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   wdsa_req_if.sink          req,
   input  logic              q_full,
   output logic              q_push,
   output logic [ITEM_W-1:0] q_data
);
   logic              slot_valid_ff, slot_valid_in;
   logic [ITEM_W-1:0] slot_ff, slot_in;
   logic [wdsa_pkg::ANG_W-1:0] ang;
   logic              take;

   assign ang     = {req.link_phase, {(wdsa_pkg::ANG_W - PHASE_WIDTH){1'b0}}};
   assign req.ready = !slot_valid_ff || !q_full;
   assign take    = req.valid && req.ready;
   assign q_push  = slot_valid_ff && !q_full;
   assign q_data  = slot_ff;

   always_comb begin
      slot_valid_in = slot_valid_ff;
      if (q_push) begin
         slot_valid_in = 1'b0;
      end
      if (take) begin
         slot_valid_in = 1'b1;
      end
      slot_in = slot_ff;
      if (take) begin
         slot_in = {req.direction,
                    req.direction == wdsa_pkg::DIR_FWD_0,
                    req.direction == wdsa_pkg::DIR_BWD_3,
                    req.direction[1],
                    req.own_up_re, req.own_up_im, req.own_dn_re, req.own_dn_im,
                    req.nbr_up_re, req.nbr_up_im, req.nbr_dn_re, req.nbr_dn_im,
                    ang};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
      end
      slot_ff <= slot_in;
   end
endmodule

// ----- rtl/wdsa_queue.sv -----
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
module wdsa_queue #(
   parameter int ITEM_W = 293
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [ITEM_W-1:0]           push_data,
   output logic                        full,
   input  logic                        pop,
   output logic                        not_empty,
   output logic [ITEM_W-1:0]           pop_data,
   output wdsa_pkg::queue_status_type  status
);
   logic [ITEM_W-1:0]               mem_ff [wdsa_pkg::QDEPTH];
   logic                            wr_ptr_ff, wr_ptr_in;
   logic                            rd_ptr_ff, rd_ptr_in;
   logic [wdsa_pkg::QCNT_W-1:0]     count_ff, count_in;

   assign full      = count_ff == wdsa_pkg::QCNT_W'(wdsa_pkg::QDEPTH);
   assign not_empty = count_ff != '0;
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign status    = '{push: push, pop: pop, count: count_ff};

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// ----- rtl/wdsa_back.sv -----
// Back end: sequencer with one shared multiplier, CORDIC unit, accumulator and output register.
`timescale 1ns / 1ps
module wdsa_back #(
   parameter int DATA_WIDTH = 32,
   parameter int ITEM_W     = 37 + 8 * DATA_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  wdsa_pkg::cfg_type    cfg,
   input  logic                 q_not_empty,
   input  logic [ITEM_W-1:0]    q_data,
   output logic                 q_pop,
   wdsa_rsp_if.source           rsp
);
   localparam int DW    = DATA_WIDTH;
   localparam int CW    = wdsa_pkg::CORDIC_W;
   localparam int AW    = (DW + 2 > CW) ? DW + 2 : CW;
   localparam int BW    = wdsa_pkg::COEF_W;
   localparam int PW    = AW + BW;
   localparam int ACC_W = DW + 8;
   localparam int TW    = ACC_W + 3;
   localparam int TPW   = DW + 2;
   localparam int AG    = wdsa_pkg::ANG_W;
   localparam int FB    = AG + 8 * DW;

   localparam logic signed [PW-1:0] HALF16 = {{(PW-16){1'b0}}, 1'b1, 15'd0};
   localparam logic signed [PW-1:0] HALF22 = {{(PW-22){1'b0}}, 1'b1, 21'd0};
   localparam logic signed [PW-1:0] HALF24 = {{(PW-24){1'b0}}, 1'b1, 23'd0};
   localparam logic signed [TW-1:0] ACC_HI = {{(TW-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
   localparam logic signed [TW-1:0] ACC_LO = {{(TW-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] OUT_HI = {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] OUT_LO = {{(ACC_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

   wdsa_pkg::back_state_type state_ff, state_in;
   logic [2:0]                 step_ff, step_in;
   logic                       phase_ff, phase_in;
   logic [wdsa_pkg::ITER_W-1:0] iter_ff, iter_in;
   logic [ITEM_W-1:0]          item_ff, item_in;
   logic signed [ACC_W-1:0]    sum_ff [4];
   logic signed [ACC_W-1:0]    sum_in [4];
   logic signed [CW-1:0]       x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [BW-1:0]       cr_ff, cr_in, ci_ff, ci_in;
   logic signed [PW-1:0]       prod_ff, prod_in;
   logic signed [TW-1:0]       temp_ff, temp_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0]       out_ff [4];
   logic signed [DW-1:0]       out_in [4];
   logic                       sat_ff, sat_in;

   logic [1:0]                 dir;
   logic                       load_own, emit_site, backward;
   logic signed [DW-1:0]       o_ur, o_ui, o_dr, o_di, n_ur, n_ui, n_dr, n_di;
   logic [AG-1:0]              ang;
   logic signed [TPW-1:0]      eur, eui, edr, edi, t0r, t0i, t1r, t1i;
   logic signed [CW-1:0]       co_w, si_w, dx, dy;
   logic signed [AW-1:0]       a_mux;
   logic signed [BW-1:0]       b_mux;
   logic signed [PW-1:0]       r_full;
   logic signed [TW-1:0]       rnd, acc_v;
   logic                       rsp_free;

   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [TW-1:0] v);
      logic signed [ACC_W-1:0] r;
      if (v > ACC_HI) begin
         r = ACC_HI[ACC_W-1:0];
      end else if (v < ACC_LO) begin
         r = ACC_LO[ACC_W-1:0];
      end else begin
         r = v[ACC_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [DW-1:0] a_base(input logic [1:0] k);
      logic signed [DW-1:0] r;
      case (k)
         2'd0:    r = o_ur;
         2'd1:    r = o_ui;
         2'd2:    r = o_dr;
         default: r = o_di;
      endcase
      return r;
   endfunction

   assign dir       = item_ff[FB+3 +: 2];
   assign load_own  = item_ff[FB+2];
   assign emit_site = item_ff[FB+1];
   assign backward  = item_ff[FB];
   assign o_ur = item_ff[AG + 7*DW +: DW];
   assign o_ui = item_ff[AG + 6*DW +: DW];
   assign o_dr = item_ff[AG + 5*DW +: DW];
   assign o_di = item_ff[AG + 4*DW +: DW];
   assign n_ur = item_ff[AG + 3*DW +: DW];
   assign n_ui = item_ff[AG + 2*DW +: DW];
   assign n_dr = item_ff[AG + 1*DW +: DW];
   assign n_di = item_ff[AG +: DW];
   assign ang  = item_ff[AG-1:0];

   assign eur = TPW'(n_ur);
   assign eui = TPW'(n_ui);
   assign edr = TPW'(n_dr);
   assign edi = TPW'(n_di);

   always_comb begin
      case (dir)
         wdsa_pkg::DIR_FWD_0: begin
            t0r = eur - edr; t0i = eui - edi; t1r = -t0r; t1i = -t0i;
         end
         wdsa_pkg::DIR_FWD_1: begin
            t0r = eur - edi; t0i = eui + edr; t1r = t0i; t1i = -t0r;
         end
         wdsa_pkg::DIR_BWD_2: begin
            t0r = eur + edr; t0i = eui + edi; t1r = t0r; t1i = t0i;
         end
         default: begin
            t0r = eur + edi; t0i = eui - edr; t1r = -t0i; t1i = t0r;
         end
      endcase
   end

   always_comb begin
      case (ang[AG-1 -: 2])
         2'd0:    begin co_w = x_ff;  si_w = y_ff;  end
         2'd1:    begin co_w = -y_ff; si_w = x_ff;  end
         2'd2:    begin co_w = -x_ff; si_w = -y_ff; end
         default: begin co_w = y_ff;  si_w = -x_ff; end
      endcase
   end

   assign dx = y_ff >>> iter_ff;
   assign dy = x_ff >>> iter_ff;

   always_comb begin
      a_mux = '0;
      b_mux = '0;
      case (state_ff)
         wdsa_pkg::ST_MU: begin
            b_mux = BW'($signed(cfg.mu));
            case (step_ff[1:0])
               2'd0:    a_mux = AW'(o_ui);
               2'd1:    a_mux = AW'(o_ur);
               2'd2:    a_mux = AW'(o_di);
               default: a_mux = AW'(o_dr);
            endcase
         end
         wdsa_pkg::ST_COEF: begin
            b_mux = BW'($signed({1'b0, cfg.kappa}));
            a_mux = step_ff[0] ? AW'(si_w) : AW'(co_w);
         end
         wdsa_pkg::ST_HOP: begin
            b_mux = step_ff[0] ? ci_ff : cr_ff;
            case (step_ff)
               3'd0:    a_mux = AW'(t0r);
               3'd1:    a_mux = AW'(t0i);
               3'd2:    a_mux = AW'(t0i);
               3'd3:    a_mux = AW'(t0r);
               3'd4:    a_mux = AW'(t1r);
               3'd5:    a_mux = AW'(t1i);
               3'd6:    a_mux = AW'(t1i);
               default: a_mux = AW'(t1r);
            endcase
         end
         default: ;
      endcase
   end

   assign prod_in = PW'(a_mux) * PW'(b_mux);

   always_comb begin
      case (state_ff)
         wdsa_pkg::ST_MU:   r_full = (prod_ff + HALF16) >>> 16;
         wdsa_pkg::ST_COEF: r_full = (prod_ff + HALF22) >>> 22;
         default:           r_full = (prod_ff + HALF24) >>> 24;
      endcase
   end
   assign rnd = r_full[TW-1:0];

   assign rsp_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      phase_in     = phase_ff;
      iter_in      = iter_ff;
      item_in      = item_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      temp_in      = temp_ff;
      sum_in       = sum_ff;
      out_in       = out_ff;
      sat_in       = sat_ff;
      q_pop        = 1'b0;
      acc_v        = '0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      case (state_ff)
         wdsa_pkg::ST_IDLE: begin
            if (q_not_empty) begin
               q_pop    = 1'b1;
               item_in  = q_data;
               state_in = wdsa_pkg::ST_SETUP;
            end
         end
         wdsa_pkg::ST_SETUP: begin
            x_in     = wdsa_pkg::CORDIC_GAIN;
            y_in     = '0;
            z_in     = CW'({1'b0, ang[AG-3:0]});
            iter_in  = '0;
            step_in  = '0;
            phase_in = 1'b0;
            state_in = load_own ? wdsa_pkg::ST_MU : wdsa_pkg::ST_CORDIC;
         end
         wdsa_pkg::ST_MU: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               if (step_ff[1:0] == 2'd0 || step_ff[1:0] == 2'd3) begin
                  acc_v = TW'(a_base(step_ff[1:0])) - rnd;
               end else begin
                  acc_v = TW'(a_base(step_ff[1:0])) + rnd;
               end
               sum_in[step_ff[1:0]] = sat_acc(acc_v);
               step_in = step_ff + 3'd1;
               if (step_ff[1:0] == 2'd3) begin
                  step_in  = '0;
                  state_in = wdsa_pkg::ST_CORDIC;
               end
            end
         end
         wdsa_pkg::ST_CORDIC: begin
            if (!z_ff[CW-1]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - wdsa_pkg::atan_turn(iter_ff);
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + wdsa_pkg::atan_turn(iter_ff);
            end
            iter_in = iter_ff + wdsa_pkg::ITER_W'(1);
            if (iter_ff == wdsa_pkg::ITER_W'(wdsa_pkg::CORDIC_STEPS - 1)) begin
               x_in     = x_ff;
               y_in     = y_ff;
               z_in     = z_ff;
               step_in  = '0;
               phase_in = 1'b0;
               state_in = wdsa_pkg::ST_COEF;
               if (!z_ff[CW-1]) begin
                  x_in = x_ff - dx;
                  y_in = y_ff + dy;
               end else begin
                  x_in = x_ff + dx;
                  y_in = y_ff - dy;
               end
            end
         end
         wdsa_pkg::ST_COEF: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               if (step_ff[0]) begin
                  ci_in    = backward ? -rnd[BW-1:0] : rnd[BW-1:0];
                  step_in  = '0;
                  state_in = wdsa_pkg::ST_HOP;
               end else begin
                  cr_in   = -rnd[BW-1:0];
                  step_in = step_ff + 3'd1;
               end
            end
         end
         wdsa_pkg::ST_HOP: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               step_in = step_ff + 3'd1;
               if (!step_ff[0]) begin
                  temp_in = TW'(sum_ff[step_ff[2:1]]) + rnd;
               end else begin
                  acc_v = step_ff[1] ? temp_ff + rnd : temp_ff - rnd;
                  sum_in[step_ff[2:1]] = sat_acc(acc_v);
                  if (step_ff == 3'd7) begin
                     step_in  = '0;
                     state_in = emit_site ? wdsa_pkg::ST_EMIT : wdsa_pkg::ST_IDLE;
                  end
               end
            end
         end
         wdsa_pkg::ST_EMIT: begin
            if (rsp_free) begin
               sat_in = 1'b0;
               for (int k = 0; k < 4; k++) begin
                  if (sum_ff[k] > OUT_HI) begin
                     out_in[k] = OUT_HI[DW-1:0];
                     sat_in    = 1'b1;
                  end else if (sum_ff[k] < OUT_LO) begin
                     out_in[k] = OUT_LO[DW-1:0];
                     sat_in    = 1'b1;
                  end else begin
                     out_in[k] = sum_ff[k][DW-1:0];
                  end
               end
               rsp_valid_in = 1'b1;
               state_in     = wdsa_pkg::ST_IDLE;
            end
         end
         default: state_in = wdsa_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wdsa_pkg::ST_IDLE;
         step_ff      <= '0;
         phase_ff     <= 1'b0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            sum_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
      end
      item_ff <= item_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      cr_ff   <= cr_in;
      ci_ff   <= ci_in;
      prod_ff <= prod_in;
      temp_ff <= temp_in;
      out_ff  <= out_in;
      sat_ff  <= sat_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_up_re = out_ff[0];
   assign rsp.out_up_im = out_ff[1];
   assign rsp.out_dn_re = out_ff[2];
   assign rsp.out_dn_im = out_ff[3];
   assign rsp.saturated = sat_ff;
endmodule

// ----- rtl/wilson_dirac_site_accumulator.sv -----
// Top level of the twisted-mass Wilson Dirac site accumulator.
// Requests carry one hop term each, directions 0 to 3 in turn; a direction-0 request
// also loads the site's own spinor times (1 +/- i*mu) into the accumulator.
// A direction-3 request produces one response with the saturated site sum and a flag.
// Both channels use valid/ready; the APB port writes kappa (0x0) and mu (0x4), which the
// user must do only while idle; the block does not enforce it. The front end registers
// each request and passes it through a two-entry queue to the back end, which works on
// one request at a time with one shared multiplier: setup, the mu steps on direction 0,
// the 24 CORDIC iterations, the coefficient steps and the hop multiplies, each multiply
// step with a multiply and an accumulate phase, then loading the response register on
// direction 3.
// Reset clears the accumulator, the queue and the response valid flag and
// restores kappa to 0.25 and mu to zero.
// A stalled response stalls the back end only at the end of a direction-3 request;
// up to three further requests are buffered meanwhile before req.ready drops.
`timescale 1ns / 1ps
module wilson_dirac_site_accumulator #(
   parameter int DATA_WIDTH  = 32,
   parameter int PHASE_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   wdsa_req_if.sink    req,
   wdsa_rsp_if.source  rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int ITEM_W = 37 + 8 * DATA_WIDTH;

   logic [wdsa_pkg::KAPPA_W-1:0] kappa_ff, kappa_in;
   logic [wdsa_pkg::MU_W-1:0]    mu_ff, mu_in;
   logic                         wr_en;
   wdsa_pkg::cfg_type            cfg;
   wdsa_pkg::queue_status_type   q_stat;
   logic                         q_push, q_full, q_pop, q_not_empty;
   logic [ITEM_W-1:0]            q_wdata, q_rdata;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign prdata = (paddr[2] == wdsa_pkg::REG_MU) ? {12'd0, mu_ff} : {16'd0, kappa_ff};
   assign cfg    = '{kappa: kappa_ff, mu: mu_ff};

   always_comb begin
      kappa_in = kappa_ff;
      mu_in    = mu_ff;
      if (wr_en) begin
         if (paddr[2] == wdsa_pkg::REG_KAPPA) begin
            kappa_in = pwdata[wdsa_pkg::KAPPA_W-1:0];
         end else begin
            mu_in = pwdata[wdsa_pkg::MU_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kappa_ff <= wdsa_pkg::KAPPA_RESET;
         mu_ff    <= wdsa_pkg::MU_RESET;
      end else begin
         kappa_ff <= kappa_in;
         mu_ff    <= mu_in;
      end
   end

   wdsa_front #(
      .DATA_WIDTH(DATA_WIDTH), .PHASE_WIDTH(PHASE_WIDTH), .ITEM_W(ITEM_W)
   ) u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_full(q_full), .q_push(q_push), .q_data(q_wdata)
   );

   wdsa_queue #(.ITEM_W(ITEM_W)) u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_wdata), .full(q_full),
      .pop(q_pop), .not_empty(q_not_empty), .pop_data(q_rdata), .status(q_stat)
   );

   wdsa_back #(.DATA_WIDTH(DATA_WIDTH), .ITEM_W(ITEM_W)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg), .q_not_empty(q_not_empty),
      .q_data(q_rdata), .q_pop(q_pop), .rsp(rsp)
   );

`ifndef SYNTH
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_stat.push |-> q_stat.count != 2'd2)
      else $error("Request pushed into a full queue.");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_stat.pop |-> q_stat.count != 2'd0)
      else $error("Request popped from an empty queue.");
   a_count_drop: assert property (@(posedge clock) disable iff (reset)
      (q_stat.pop && !q_stat.push) |=> q_stat.count == $past(q_stat.count) - 2'd1)
      else $error("Queue count did not follow a pop.");
`endif
endmodule
